/* src/rsi_pkg.sv */
// Shared constants and register codes for the ray and sphere intersection pipeline.
package rsi_pkg;

  localparam int COORD_WIDTH_DEF = 32;
  localparam int DIR_WIDTH       = 18;
  localparam int FRAC_BITS       = 16;
  localparam int CFG_INDEX_WIDTH = 2;

  // Reset values in Q.16: center z is 20.0 and the radius is 5.0.
  localparam logic [63:0] CENTER_Z_RESET = 64'd1310720;
  localparam logic [63:0] RADIUS_RESET   = 64'd327680;

  typedef enum logic [CFG_INDEX_WIDTH-1:0] {
    CFG_CENTER_X = 2'd0,
    CFG_CENTER_Y = 2'd1,
    CFG_CENTER_Z = 2'd2,
    CFG_RADIUS   = 2'd3
  } cfg_index_t;

endpackage

/* src/rsi_square.sv */
// Two-stage squarer of an unsigned magnitude, built from half-width partial products.
module rsi_square #(
  parameter int MW = 33
) (
  input  logic            clk,
  input  logic            en,
  input  logic [MW-1:0]   mag,
  output logic [2*MW-1:0] sq
);

  localparam int LW = (MW + 1) / 2;
  localparam int HW = MW - LW;

  logic [2*HW-1:0] hh;
  logic [MW-1:0]   hl;
  logic [2*LW-1:0] ll;

  always_ff @(posedge clk) begin
    if (en) begin
      hh <= mag[MW-1:LW] * mag[MW-1:LW];
      hl <= mag[MW-1:LW] * mag[LW-1:0];
      ll <= mag[LW-1:0] * mag[LW-1:0];
      // The cross term appears twice, hence the extra bit of shift.
      sq <= ({{(2*LW){1'b0}}, hh} << (2*LW))
          + ({{MW{1'b0}}, hl} << (LW + 1))
          + {{(2*HW){1'b0}}, ll};
    end
  end

endmodule

/* src/rsi_front.sv */
// Front pipeline: offset from the center, dot products, squares and the discriminant.
module rsi_front #(
  parameter int COORD_WIDTH = rsi_pkg::COORD_WIDTH_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 en,
  input  logic                                 in_vld,
  input  logic signed [COORD_WIDTH-1:0]        org [3],
  input  logic signed [rsi_pkg::DIR_WIDTH-1:0] dir [3],
  input  logic signed [COORD_WIDTH-1:0]        center [3],
  input  logic [COORD_WIDTH-2:0]               radius,
  output logic                                 out_vld,
  output logic                                 out_hit,
  output logic [2*COORD_WIDTH+7:0]             out_d,
  output logic signed [COORD_WIDTH+4:0]        out_b16
);

  localparam int W    = COORD_WIDTH;
  localparam int RSW  = W + 1;
  localparam int PBW  = RSW + rsi_pkg::DIR_WIDTH;
  localparam int B16W = W + 5;
  localparam int BW   = B16W + rsi_pkg::FRAC_BITS;
  localparam int CW   = 2 * W + 3;
  localparam int DW   = 2 * W + 12;
  localparam logic signed [BW-1:0] HALF =
    {{(BW - rsi_pkg::FRAC_BITS){1'b0}}, 1'b1, {(rsi_pkg::FRAC_BITS - 1){1'b0}}};

  logic [7:1] vld;

  logic signed [RSW-1:0]                 rs_q [3];
  logic signed [rsi_pkg::DIR_WIDTH-1:0]  dir_q [3];
  logic signed [PBW-1:0]                 pb_q [3];
  logic [RSW-1:0]                        rs_mag [3];
  logic [2*RSW-1:0]                      rs_sq [3];
  logic [2*W-3:0]                        r_sq;

  logic signed [BW-1:0]   bsum_q;
  logic signed [CW-1:0]   c_q, c5, c6;
  logic signed [B16W-1:0] b16_q, b5, b6;
  logic [B16W-1:0]        b16_mag;
  logic [2*B16W-1:0]      b16_sq;
  logic signed [DW-1:0]   d_full;
  logic                   d_pos;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[6:1], in_vld};
    end
  end

  for (genvar i = 0; i < 3; i++) begin : g_lane
    always_ff @(posedge clk) begin
      if (en) begin
        rs_q[i]  <= RSW'(org[i]) - RSW'(center[i]);
        dir_q[i] <= dir[i];
        pb_q[i]  <= rs_q[i] * dir_q[i];
      end
    end

    assign rs_mag[i] = rs_q[i][RSW-1] ? RSW'(-rs_q[i]) : RSW'(rs_q[i]);

    rsi_square #(.MW(RSW)) u_sq_rs (
      .clk (clk),
      .en  (en),
      .mag (rs_mag[i]),
      .sq  (rs_sq[i])
    );
  end

  // The user must keep the radius static while items are in flight; the block itself
  // does not enforce this. It then enters with the offsets of the same item.
  rsi_square #(.MW(W - 1)) u_sq_radius (
    .clk (clk),
    .en  (en),
    .mag (radius),
    .sq  (r_sq)
  );

  assign b16_mag = b16_q[B16W-1] ? B16W'(-b16_q) : B16W'(b16_q);

  rsi_square #(.MW(B16W)) u_sq_b16 (
    .clk (clk),
    .en  (en),
    .mag (b16_mag),
    .sq  (b16_sq)
  );

  assign d_full = $signed(DW'(b16_sq)) - DW'(c6);
  assign d_pos  = !d_full[DW-1] && (d_full != '0);

  always_ff @(posedge clk) begin
    if (en) begin
      bsum_q  <= BW'(pb_q[0]) + BW'(pb_q[1]) + BW'(pb_q[2]) + HALF;
      c_q     <= $signed(CW'(rs_sq[0])) + $signed(CW'(rs_sq[1]))
               + $signed(CW'(rs_sq[2])) - $signed(CW'(r_sq));
      // Rounded B in Q.16: the upper bits of the biased Q.32 sum.
      b16_q   <= bsum_q[BW-1:rsi_pkg::FRAC_BITS];
      c5      <= c_q;
      b5      <= b16_q;
      c6      <= c5;
      b6      <= b5;
      out_hit <= d_pos;
      out_d   <= d_pos ? d_full[2*W+7:0] : '0;
      out_b16 <= b6;
    end
  end

  assign out_vld = vld[7];

endmodule

/* src/rsi_sqrt.sv */
// Pipelined floor square root, one result bit per stage, with the item's side data.
module rsi_sqrt #(
  parameter int COORD_WIDTH = rsi_pkg::COORD_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          en,
  input  logic                          in_vld,
  input  logic                          in_hit,
  input  logic [2*COORD_WIDTH+7:0]      in_d,
  input  logic signed [COORD_WIDTH+4:0] in_b16,
  output logic                          out_vld,
  output logic                          out_hit,
  output logic [COORD_WIDTH+3:0]        out_root,
  output logic signed [COORD_WIDTH+4:0] out_b16
);

  localparam int RW   = COORD_WIDTH + 4;
  localparam int REMW = RW + 3;
  localparam int B16W = COORD_WIDTH + 5;

  logic [RW-1:0]          vld_q;
  logic [REMW-1:0]        rem_q  [RW];
  logic [RW-1:0]          root_q [RW];
  logic [2*RW-1:0]        dd_q   [RW];
  logic                   hit_q  [RW];
  logic signed [B16W-1:0] b16_q  [RW];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[RW-2:0], in_vld};
    end
  end

  for (genvar k = 0; k < RW; k++) begin : g_stage
    logic [REMW-1:0]        rem_in;
    logic [RW-1:0]          root_in;
    logic [2*RW-1:0]        dd_in;
    logic                   hit_in;
    logic signed [B16W-1:0] b16_in;
    logic [REMW-1:0]        rem_sh;
    logic [REMW-1:0]        trial;
    logic                   take_bit;

    if (k == 0) begin : g_first
      assign rem_in  = '0;
      assign root_in = '0;
      assign dd_in   = in_d;
      assign hit_in  = in_hit;
      assign b16_in  = in_b16;
    end else begin : g_next
      assign rem_in  = rem_q[k-1];
      assign root_in = root_q[k-1];
      assign dd_in   = dd_q[k-1];
      assign hit_in  = hit_q[k-1];
      assign b16_in  = b16_q[k-1];
    end

    // Bring down the next two radicand bits and try the next root bit as one.
    assign rem_sh   = {rem_in[REMW-3:0], dd_in[2*RW-1:2*RW-2]};
    assign trial    = REMW'({root_in, 2'b01});
    assign take_bit = rem_sh >= trial;

    always_ff @(posedge clk) begin
      if (en) begin
        rem_q[k]  <= take_bit ? rem_sh - trial : rem_sh;
        root_q[k] <= {root_in[RW-2:0], take_bit};
        dd_q[k]   <= {dd_in[2*RW-3:0], 2'b00};
        hit_q[k]  <= hit_in;
        b16_q[k]  <= b16_in;
      end
    end
  end

  assign out_vld  = vld_q[RW-1];
  assign out_hit  = hit_q[RW-1];
  assign out_root = root_q[RW-1];
  assign out_b16  = b16_q[RW-1];

endmodule

/* src/rsi_out.sv */
// Near-root distance with saturation, output register and skid register.
module rsi_out #(
  parameter int COORD_WIDTH = rsi_pkg::COORD_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  output logic                          en,
  input  logic                          in_vld,
  input  logic                          in_hit,
  input  logic [COORD_WIDTH+3:0]        in_root,
  input  logic signed [COORD_WIDTH+4:0] in_b16,
  output logic                          out_vld,
  input  logic                          out_ready,
  output logic                          out_hit,
  output logic [COORD_WIDTH-1:0]        out_dist
);

  localparam int W   = COORD_WIDTH;
  localparam int DFW = W + 6;
  localparam logic signed [DFW-1:0] MAXV = {{(DFW-W+1){1'b0}}, {(W-1){1'b1}}};
  localparam logic signed [DFW-1:0] MINV = {{(DFW-W+1){1'b1}}, {(W-1){1'b0}}};

  logic signed [DFW-1:0] dist_full;
  logic [W-1:0]          new_dist;
  logic                  take;
  logic                  load_out;
  logic                  load_skid;
  logic                  skid_vld;
  logic                  skid_hit;
  logic [W-1:0]          skid_dist;
  logic                  out_vld_next;
  logic                  skid_vld_next;

  assign dist_full = -DFW'(in_b16) - $signed(DFW'(in_root));

  always_comb begin
    if (!in_hit) begin
      new_dist = MAXV[W-1:0];
    end else if (dist_full > MAXV) begin
      new_dist = MAXV[W-1:0];
    end else if (dist_full < MINV) begin
      new_dist = MINV[W-1:0];
    end else begin
      new_dist = dist_full[W-1:0];
    end
  end

  // The whole pipeline moves only while the skid register is empty.
  assign en        = !skid_vld;
  assign take      = in_vld && en;
  assign load_out  = skid_vld ? out_ready : (take && (!out_vld || out_ready));
  assign load_skid = take && out_vld && !out_ready;

  always_comb begin
    out_vld_next  = out_vld;
    skid_vld_next = skid_vld;
    if (load_out) begin
      out_vld_next = 1'b1;
    end else if (out_ready) begin
      out_vld_next = 1'b0;
    end
    if (load_skid) begin
      skid_vld_next = 1'b1;
    end else if (skid_vld && out_ready) begin
      skid_vld_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld  <= 1'b0;
      skid_vld <= 1'b0;
    end else begin
      out_vld  <= out_vld_next;
      skid_vld <= skid_vld_next;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_hit  <= skid_vld ? skid_hit : in_hit;
      out_dist <= skid_vld ? skid_dist : new_dist;
    end
    if (load_skid) begin
      skid_hit  <= in_hit;
      skid_dist <= new_dist;
    end
  end

endmodule

/* src/ray_sphere_intersect_top.sv */
// Top level of the ray and sphere intersection pipeline, with the sphere registers.
//
//   Channel   Signals                                 Carries
//   s_*       s_tvalid s_tready s_tdata               one ray: origin and direction
//   m_*       m_tvalid m_tready m_tdata m_tuser       hit flag and near distance
//   cfg_*     cfg_valid cfg_ready cfg_index cfg_data  sphere center and radius writes
//
// One ray is taken every cycle while the skid register is empty. Its result passes
// through seven front stages, one stage per root bit in the square root, and the
// output register.
// Reset clears the valid bits and loads the default sphere; no clearing pass.
// A held output parks one result in a skid register, and the pipeline then holds
// in place from the next cycle on, so no ray is dropped or repeated.
module ray_sphere_intersect_top #(
  parameter int COORD_WIDTH = rsi_pkg::COORD_WIDTH_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   s_tvalid,
  output logic                                   s_tready,
  // org_x, org_y, org_z, dir_x, dir_y, dir_z, zero fill
  input  logic [((3*COORD_WIDTH+3*rsi_pkg::DIR_WIDTH+7)/8)*8-1:0] s_tdata,
  output logic                                   m_tvalid,
  input  logic                                   m_tready,
  // distance, zero fill
  output logic [((COORD_WIDTH+7)/8)*8-1:0]       m_tdata,
  // hit
  output logic                                   m_tuser,
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [rsi_pkg::CFG_INDEX_WIDTH-1:0]    cfg_index,
  input  logic [COORD_WIDTH-1:0]                 cfg_data
);

  localparam int W     = COORD_WIDTH;
  localparam int DIRW  = rsi_pkg::DIR_WIDTH;
  localparam int OUT_W = ((W + 7) / 8) * 8;

  logic signed [W-1:0]    org [3];
  logic signed [DIRW-1:0] dir [3];
  logic signed [W-1:0]    center [3];
  logic [W-2:0]           radius;

  logic                   en;
  logic                   fr_vld;
  logic                   fr_hit;
  logic [2*W+7:0]         fr_d;
  logic signed [W+4:0]    fr_b16;
  logic                   sq_vld;
  logic                   sq_hit;
  logic [W+3:0]           sq_root;
  logic signed [W+4:0]    sq_b16;
  logic [W-1:0]           near_dist;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      center[0] <= '0;
      center[1] <= '0;
      center[2] <= rsi_pkg::CENTER_Z_RESET[W-1:0];
      radius    <= rsi_pkg::RADIUS_RESET[W-2:0];
    end else if (cfg_valid) begin
      case (rsi_pkg::cfg_index_t'(cfg_index))
        rsi_pkg::CFG_CENTER_X: center[0] <= cfg_data;
        rsi_pkg::CFG_CENTER_Y: center[1] <= cfg_data;
        rsi_pkg::CFG_CENTER_Z: center[2] <= cfg_data;
        rsi_pkg::CFG_RADIUS:   radius    <= cfg_data[W-2:0];
        default: ;
      endcase
    end
  end

  for (genvar i = 0; i < 3; i++) begin : g_unpack
    assign org[i] = s_tdata[i*W +: W];
    assign dir[i] = s_tdata[3*W + i*DIRW +: DIRW];
  end

  assign s_tready = en;

  rsi_front #(.COORD_WIDTH(W)) u_front (
    .clk     (clk),
    .rst     (rst),
    .en      (en),
    .in_vld  (s_tvalid),
    .org     (org),
    .dir     (dir),
    .center  (center),
    .radius  (radius),
    .out_vld (fr_vld),
    .out_hit (fr_hit),
    .out_d   (fr_d),
    .out_b16 (fr_b16)
  );

  rsi_sqrt #(.COORD_WIDTH(W)) u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_vld   (fr_vld),
    .in_hit   (fr_hit),
    .in_d     (fr_d),
    .in_b16   (fr_b16),
    .out_vld  (sq_vld),
    .out_hit  (sq_hit),
    .out_root (sq_root),
    .out_b16  (sq_b16)
  );

  rsi_out #(.COORD_WIDTH(W)) u_out (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_vld    (sq_vld),
    .in_hit    (sq_hit),
    .in_root   (sq_root),
    .in_b16    (sq_b16),
    .out_vld   (m_tvalid),
    .out_ready (m_tready),
    .out_hit   (m_tuser),
    .out_dist  (near_dist)
  );

  assign m_tdata = OUT_W'(near_dist);

endmodule

/* sim/rsi_checker.sv */
// Channel monitor for the ray and sphere pipeline: predicts each intersection and checks results.
module rsi_checker #(
  parameter int COORD_WIDTH = rsi_pkg::COORD_WIDTH_DEF
) (
  input  logic                                                   clk,
  input  logic                                                   rst,
  input  logic                                                   s_tvalid,
  input  logic                                                   s_tready,
  input  logic [((3*COORD_WIDTH+3*rsi_pkg::DIR_WIDTH+7)/8)*8-1:0] s_tdata,
  input  logic                                                   m_tvalid,
  input  logic                                                   m_tready,
  input  logic [((COORD_WIDTH+7)/8)*8-1:0]                       m_tdata,
  input  logic                                                   m_tuser,
  input  logic                                                   cfg_valid,
  input  logic                                                   cfg_ready,
  input  logic [rsi_pkg::CFG_INDEX_WIDTH-1:0]                    cfg_index,
  input  logic [COORD_WIDTH-1:0]                                 cfg_data,
  output int                                                     mismatches,
  output int                                                     outstanding
);

  localparam int DIRW  = rsi_pkg::DIR_WIDTH;
  localparam int RAY_W = ((3*COORD_WIDTH + 3*DIRW + 7) / 8) * 8;
  localparam logic signed [127:0] DIST_MAX = (128'sd1 <<< (COORD_WIDTH - 1)) - 128'sd1;
  localparam logic signed [127:0] DIST_MIN = -(128'sd1 <<< (COORD_WIDTH - 1));

  typedef struct packed {
    logic                   hit;
    logic [COORD_WIDTH-1:0] distance;
  } ray_result_t;

  logic signed [COORD_WIDTH-1:0] center_x, center_y, center_z;
  logic [COORD_WIDTH-2:0]        radius;
  ray_result_t                   due_results[$];
  ray_result_t                   want;

  // All sums and products are kept in 128 bits, wide enough that nothing wraps.
  function automatic ray_result_t intersect_ray(input logic [RAY_W-1:0] ray);
    logic signed [COORD_WIDTH-1:0] org, cen;
    logic signed [DIRW-1:0]        dir;
    logic signed [127:0]           org_w, cen_w, dir_w, rs, b32, cq, rr, b16, disc, root_w;
    logic signed [127:0]           near_dist;
    logic [127:0]                  trial_sq;
    logic [63:0]                   root, trial;
    ray_result_t                   res;
    b32 = '0;
    cq  = '0;
    for (int i = 0; i < 3; i++) begin
      org   = ray[COORD_WIDTH*i +: COORD_WIDTH];
      cen   = (i == 0) ? center_x : (i == 1) ? center_y : center_z;
      dir   = ray[3*COORD_WIDTH + DIRW*i +: DIRW];
      org_w = org;
      cen_w = cen;
      dir_w = dir;
      rs    = org_w - cen_w;
      b32   = b32 + rs * dir_w;
      cq    = cq + rs * rs;
    end
    rr   = {{(128-COORD_WIDTH+1){1'b0}}, radius};
    cq   = cq - rr * rr;
    b16  = (b32 + 128'sd32768) >>> rsi_pkg::FRAC_BITS;
    disc = b16 * b16 - cq;
    if (disc > 128'sd0) begin
      root = '0;
      for (int b = 63; b >= 0; b--) begin
        trial    = root | (64'd1 << b);
        trial_sq = {64'd0, trial} * {64'd0, trial};
        if (trial_sq <= $unsigned(disc)) root = trial;
      end
      root_w    = {64'd0, root};
      near_dist = -b16 - root_w;
      if (near_dist > DIST_MAX) near_dist = DIST_MAX;
      if (near_dist < DIST_MIN) near_dist = DIST_MIN;
      res.hit      = 1'b1;
      res.distance = near_dist[COORD_WIDTH-1:0];
    end else begin
      // A miss or a grazing ray reports the largest positive distance.
      res.hit      = 1'b0;
      res.distance = DIST_MAX[COORD_WIDTH-1:0];
    end
    return res;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      center_x    = '0;
      center_y    = '0;
      center_z    = rsi_pkg::CENTER_Z_RESET[COORD_WIDTH-1:0];
      radius      = rsi_pkg::RADIUS_RESET[COORD_WIDTH-2:0];
      mismatches  = 0;
      due_results.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          rsi_pkg::CFG_CENTER_X: center_x = cfg_data;
          rsi_pkg::CFG_CENTER_Y: center_y = cfg_data;
          rsi_pkg::CFG_CENTER_Z: center_z = cfg_data;
          rsi_pkg::CFG_RADIUS:   radius   = cfg_data[COORD_WIDTH-2:0];
          default: ;
        endcase
      end
      if (s_tvalid && s_tready) due_results.push_back(intersect_ray(s_tdata));
      if (m_tvalid && m_tready) begin
        if (due_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("Result transfer with none outstanding: hit %0b distance %0d",
                     m_tuser, $signed(m_tdata[COORD_WIDTH-1:0]));
        end else begin
          want = due_results.pop_front();
          if (m_tuser !== want.hit || m_tdata[COORD_WIDTH-1:0] !== want.distance) begin
            mismatches++;
            if (mismatches <= 10)
              $display("Result mismatch: expected hit %0b distance %0d, got hit %0b distance %0d",
                       want.hit, $signed(want.distance),
                       m_tuser, $signed(m_tdata[COORD_WIDTH-1:0]));
          end
        end
      end
    end
    outstanding = due_results.size();
  end

endmodule

/* sim/tb_ray_sphere_intersect_top.sv */
// Testbench top: drives rays and sphere register writes into the pipeline and gives the verdict.
module tb_ray_sphere_intersect_top;

  localparam int CW          = rsi_pkg::COORD_WIDTH_DEF;
  localparam int DIRW        = rsi_pkg::DIR_WIDTH;
  localparam int RAY_W       = ((3*CW + 3*DIRW + 7) / 8) * 8;
  localparam int OUT_W       = ((CW + 7) / 8) * 8;
  localparam int LATENCY     = CW + 12;
  localparam int CYCLE_LIMIT = 200000;
  localparam int ONE         = 1 << rsi_pkg::FRAC_BITS;
  localparam int DIR_MAX     = (1 << (DIRW - 1)) - 1;
  localparam int DIR_MIN     = -(1 << (DIRW - 1));
  localparam int POS_MAX     = 32'sh7fffffff;
  localparam int NEG_MIN     = 32'sh80000000;

  logic                                clk;
  logic                                rst;
  logic                                s_tvalid;
  logic                                s_tready;
  logic [RAY_W-1:0]                    s_tdata;
  logic                                m_tvalid;
  logic                                m_tready = 1'b1;
  logic [OUT_W-1:0]                    m_tdata;
  logic                                m_tuser;
  logic                                cfg_valid;
  logic                                cfg_ready;
  logic [rsi_pkg::CFG_INDEX_WIDTH-1:0] cfg_index;
  logic [CW-1:0]                       cfg_data;

  int idle_pct;
  int stall_pct;
  int mismatches;
  int outstanding;
  int cycles;
  // Copy of the sphere as last written, used to aim rays at it.
  int sph_cx, sph_cy, sph_cz, sph_r;

  ray_sphere_intersect_top u_top (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  rsi_checker u_checker (
    .clk         (clk),
    .rst         (rst),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .m_tuser     (m_tuser),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  always @(negedge clk) begin
    m_tready <= ($urandom_range(0, 99) >= stall_pct);
  end

  // Called at a falling edge; returns at the falling edge after the transfer with
  // tvalid still high, so back-to-back rays keep it high.
  task automatic send_ray(input int ox, input int oy, input int oz,
                          input int dx, input int dy, input int dz);
    logic [RAY_W-1:0] word;
    word = '0;
    word[0 +: CW]                 = ox;
    word[CW +: CW]                = oy;
    word[2*CW +: CW]              = oz;
    word[3*CW +: DIRW]            = dx[DIRW-1:0];
    word[3*CW + DIRW +: DIRW]     = dy[DIRW-1:0];
    word[3*CW + 2*DIRW +: DIRW]   = dz[DIRW-1:0];
    while ($urandom_range(0, 99) < idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= word;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic hold_until_drained();
    s_tvalid <= 1'b0;
    @(negedge clk);
    while (outstanding != 0) @(negedge clk);
  endtask

  task automatic write_reg(input rsi_pkg::cfg_index_t idx, input logic [CW-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic load_sphere(input int cx, input int cy, input int cz,
                             input logic [CW-1:0] rdata);
    write_reg(rsi_pkg::CFG_CENTER_X, cx);
    write_reg(rsi_pkg::CFG_CENTER_Y, cy);
    write_reg(rsi_pkg::CFG_CENTER_Z, cz);
    write_reg(rsi_pkg::CFG_RADIUS, rdata);
    cfg_valid <= 1'b0;
    @(negedge clk);
    sph_cx = cx;
    sph_cy = cy;
    sph_cz = cz;
    sph_r  = int'(rdata & 32'h7fffffff);
  endtask

  function automatic int near_origin();
    return int'($urandom_range(0, 1 << 27)) - (1 << 26);
  endfunction

  function automatic real jitter();
    return real'(int'($urandom_range(0, 2000)) - 1000) / 1000.0;
  endfunction

  // Scales a direction to unit length in Q1.16.
  task automatic aim_dir(input real tx, input real ty, input real tz,
                         output int dx, output int dy, output int dz);
    real len;
    len = $sqrt(tx * tx + ty * ty + tz * tz);
    if (len < 1.0e-9) begin
      dx = 0;
      dy = 0;
      dz = ONE;
    end else begin
      dx = int'(tx / len * 65536.0);
      dy = int'(ty / len * 65536.0);
      dz = int'(tz / len * 65536.0);
    end
  endtask

  task automatic send_random_ray();
    int  kind, lim_r, span, ax, bx, k, sgn, delta;
    int  off[3];
    int  dv[3];
    real spread;
    kind   = $urandom_range(0, 99);
    lim_r  = (sph_r > (1 << 24)) ? (1 << 24) : sph_r;
    span   = 4 * lim_r + int'($urandom_range(0, 1 << 20)) + 1;
    spread = 2.0 * real'(lim_r);
    for (int i = 0; i < 3; i++) off[i] = int'($urandom_range(0, 2 * span)) - span;
    if (kind < 55) begin
      // Aimed at the center with some scatter, so hits and near misses both occur.
      aim_dir(-real'(off[0]) + spread * jitter(), -real'(off[1]) + spread * jitter(),
              -real'(off[2]) + spread * jitter(), dv[0], dv[1], dv[2]);
      send_ray(sph_cx + off[0], sph_cy + off[1], sph_cz + off[2], dv[0], dv[1], dv[2]);
    end else if (kind < 70) begin
      aim_dir(jitter(), jitter(), jitter(), dv[0], dv[1], dv[2]);
      send_ray(sph_cx + off[0], sph_cy + off[1], sph_cz + off[2], dv[0], dv[1], dv[2]);
    end else if (kind < 85) begin
      send_ray($urandom, $urandom, $urandom, $urandom_range(0, (1 << DIRW) - 1),
               $urandom_range(0, (1 << DIRW) - 1), $urandom_range(0, (1 << DIRW) - 1));
    end else begin
      // Axis-aligned ray passing at one radius from the center: exactly grazing
      // when delta is zero, just inside or just outside otherwise.
      ax    = $urandom_range(0, 2);
      bx    = (ax + 1 + $urandom_range(0, 1)) % 3;
      k     = $urandom_range(0, 1 << 20);
      sgn   = $urandom_range(0, 1) ? 1 : -1;
      delta = int'($urandom_range(0, 2)) - 1;
      for (int i = 0; i < 3; i++) begin
        off[i] = 0;
        dv[i]  = 0;
      end
      off[ax] = sph_r + delta;
      off[bx] = -sgn * k;
      dv[bx]  = sgn * ONE;
      send_ray(sph_cx + off[0], sph_cy + off[1], sph_cz + off[2], dv[0], dv[1], dv[2]);
    end
  endtask

  initial begin
    rst       = 1'b1;
    s_tvalid  = 1'b0;
    s_tdata   = '0;
    cfg_valid = 1'b0;
    cfg_index = rsi_pkg::CFG_CENTER_X;
    cfg_data  = '0;
    idle_pct  = 0;
    stall_pct = 0;
    sph_cx    = 0;
    sph_cy    = 0;
    sph_cz    = 20 * ONE;
    sph_r     = 5 * ONE;
    repeat (7) @(negedge clk);
    rst <= 1'b0;

    // Directed rays against the sphere loaded by reset.
    send_ray(0, 0, 0, 0, 0, ONE);
    send_ray(0, 0, 0, 0, 0, -ONE);
    send_ray(0, 0, 0, ONE, 0, 0);
    send_ray(5 * ONE, 0, 0, 0, 0, ONE);
    send_ray(5 * ONE - 1, 0, 0, 0, 0, ONE);
    send_ray(0, 0, 20 * ONE, 0, ONE, 0);
    send_ray(0, 0, 0, 0, 0, 0);
    send_ray(0, 0, 20 * ONE, 0, 0, 0);
    send_ray(POS_MAX, POS_MAX, POS_MAX, DIR_MAX, DIR_MAX, DIR_MAX);
    send_ray(NEG_MIN, NEG_MIN, NEG_MIN, DIR_MIN, DIR_MIN, DIR_MIN);
    send_ray(NEG_MIN, 0, 0, DIR_MIN, 0, 0);
    send_ray(NEG_MIN, NEG_MIN, NEG_MIN, DIR_MAX, 0, 0);
    send_ray(0, 0, 0, 0, 0, ONE / 2);
    send_ray(1, -1, 32'h12345678, 0, ONE, -1);
    send_ray(32'h55555555, 32'haaaaaaaa, 32'h55555555, 87381, -87382, 87381);
    send_ray(32'haaaaaaaa, 32'h55555555, 32'haaaaaaaa, -87382, 87381, -87382);

    // Extreme center with the radius bit above the register width set, leaving radius zero.
    hold_until_drained();
    load_sphere(NEG_MIN, POS_MAX, NEG_MIN, 32'h80000000);
    send_ray(POS_MAX, NEG_MIN, POS_MAX, DIR_MIN, DIR_MAX, DIR_MIN);
    send_ray(NEG_MIN, POS_MAX, NEG_MIN, ONE, 0, 0);
    send_ray(NEG_MIN + ONE, POS_MAX, NEG_MIN, -ONE, 0, 0);
    send_ray(0, 0, 0, DIR_MAX, DIR_MAX, DIR_MAX);

    for (int ph = 0; ph < 4; ph++) begin
      hold_until_drained();
      case (ph)
        0: begin
          load_sphere(near_origin(), near_origin(), near_origin(), $urandom_range(1 << 14, 1 << 22));
          idle_pct  = 0;
          stall_pct = 0;
        end
        1: begin
          load_sphere(near_origin(), near_origin(), near_origin(), $urandom_range(1 << 14, 1 << 22));
          idle_pct  = 75;
          stall_pct = 0;
        end
        2: begin
          load_sphere(POS_MAX, NEG_MIN, 0, 32'hffffffff);
          idle_pct  = 0;
          stall_pct = 75;
        end
        default: begin
          load_sphere(near_origin(), near_origin(), near_origin(), $urandom_range(0, 1 << 23));
          idle_pct  = 22;
          stall_pct = 22;
        end
      endcase
      for (int n = 0; n < 95; n++) begin
        if ((ph == 1 && n == 40) || $urandom_range(0, 99) < 2) hold_until_drained();
        send_random_ray();
      end
    end

    hold_until_drained();
    repeat (LATENCY + 16) @(negedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
